@@ rtl/sparse_set_entity_store_defines.svh @@
// Assertion macros shared by the entity store RTL.
`ifndef SPARSE_SET_ENTITY_STORE_DEFINES_SVH
`define SPARSE_SET_ENTITY_STORE_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define SSES_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define SSES_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/sses_pkg.sv @@
// Types, codes and sizes shared by the entity store modules.
`default_nettype none
package sses_pkg;
	localparam int ENTITY_SLOTS = 256;
	localparam int TYPE_SLOTS   = 8;
	localparam int DATA_W       = 32;
	localparam int ENT_W        = 8;
	localparam int TYPE_W       = 3;
	localparam int FILL_W       = 9;
	localparam int CNT_W        = 4;
	localparam int SLOT_AW      = TYPE_W + ENT_W;
	localparam int DENSE_DEPTH  = TYPE_SLOTS * ENTITY_SLOTS;

	localparam logic [2:0] OP_CREATE  = 3'd0;
	localparam logic [2:0] OP_DESTROY = 3'd1;
	localparam logic [2:0] OP_ADD     = 3'd2;
	localparam logic [2:0] OP_REMOVE  = 3'd3;
	localparam logic [2:0] OP_GET     = 3'd4;

	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_BAD_TYPE   = 3'd1;
	localparam logic [2:0] STAT_BAD_ENTITY = 3'd2;
	localparam logic [2:0] STAT_PRESENT    = 3'd3;
	localparam logic [2:0] STAT_ABSENT     = 3'd4;
	localparam logic [2:0] STAT_FULL       = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_CHECK,
		ST_MOVE,
		ST_POP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             pop;
		logic             push;
		logic             take_fresh;
		logic [ENT_W-1:0] push_id;
	} alloc_ctl_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic              fresh_out;
		logic [FILL_W-1:0] next_id;
	} alloc_stat_t;
endpackage
`default_nettype wire

@@ rtl/sses_alloc.sv @@
// Entity id allocator: fresh id counter and LIFO stack of freed ids.
`default_nettype none
module sses_alloc (
	input  wire                        clk,
	input  wire                        arst_n,
	input  sses_pkg::alloc_ctl_t       ctl,
	output sses_pkg::alloc_stat_t      stat,
	output logic [sses_pkg::ENT_W-1:0] pop_id
);
	import sses_pkg::*;

	logic [ENT_W-1:0]  stack_mem [ENTITY_SLOTS];
	logic [FILL_W-1:0] depth_q;
	logic [FILL_W-1:0] next_q;
	logic [FILL_W-1:0] depth_m1;

	assign depth_m1 = depth_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			next_q  <= FILL_W'(1);
		end else begin
			if (ctl.pop) begin
				depth_q <= depth_m1;
			end else if (ctl.push) begin
				depth_q <= depth_q + 1'b1;
			end
			if (ctl.take_fresh) begin
				next_q <= next_q + 1'b1;
			end
		end
	end

	// The popped id is registered, so it arrives in the cycle after the pop.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stack_mem[depth_q[ENT_W-1:0]] <= ctl.push_id;
		end
		if (ctl.pop) begin
			pop_id <= stack_mem[depth_m1[ENT_W-1:0]];
		end
	end

	assign stat.empty     = (depth_q == '0);
	assign stat.full      = (depth_q == FILL_W'(ENTITY_SLOTS));
	assign stat.fresh_out = (next_q >= FILL_W'(ENTITY_SLOTS));
	assign stat.next_id   = next_q;
endmodule
`default_nettype wire

@@ rtl/sparse_set_entity_store.sv @@
// Top level of the entity store: sequencer, sparse and dense memories, result register.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | op, entity_id, comp_type, data_in
//  out     | output    | out_valid / out_stall| new_entity, data_out, status
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (types_in_use)
//
// Create passes ST_POP for a freed id, else straight to ST_EMIT; get and add pass ST_LOOKUP
// and ST_CHECK, remove also ST_MOVE, as they read the sparse memory, the dense memory and,
// for remove, the last dense entry. Destroy makes one lookup per registered type: ST_LOOKUP,
// ST_CHECK and, for a member, ST_MOVE. Rejected items go straight to ST_EMIT. Reset clears
// all control state at once; memories need no clearing since membership is checked against
// the dense array. A stalled result holds the sequencer in ST_EMIT; no new transfer is taken.
`default_nettype none
`include "sparse_set_entity_store_defines.svh"
module sparse_set_entity_store (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  op,
	input  wire  [7:0]  entity_id,
	input  wire  [2:0]  comp_type,
	input  wire  [31:0] data_in,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  new_entity,
	output logic [31:0] data_out,
	output logic [2:0]  status,
	input  wire         cfg_wr_en,
	input  wire  [3:0]  cfg_wr_data
);
	import sses_pkg::*;

	localparam int DN_W = ENT_W + DATA_W;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  types_q;
	logic [CNT_W-1:0]  active;
	logic [FILL_W-1:0] fill_q [TYPE_SLOTS];

	logic [2:0]        op_q;
	logic [ENT_W-1:0]  e_q;
	logic [DATA_W-1:0] d_q;
	logic [TYPE_W-1:0] t_q, t_d;
	logic [ENT_W-1:0]  hole_q, hole_d;

	logic [ENT_W-1:0]  res_new_q, res_new_d;
	logic [DATA_W-1:0] res_data_q, res_data_d;
	logic [2:0]        res_stat_q, res_stat_d;

	logic              out_valid_q;
	logic [ENT_W-1:0]  out_new_q;
	logic [DATA_W-1:0] out_data_q;
	logic [2:0]        out_stat_q;

	logic [ENT_W-1:0]  sp_mem [DENSE_DEPTH];
	logic [DN_W-1:0]   dn_mem [DENSE_DEPTH];
	logic [ENT_W-1:0]  sp_rdata_q;
	logic [DN_W-1:0]   dn_rdata_q;

	logic              sp_re, sp_we, dn_re, dn_we;
	logic [SLOT_AW-1:0] sp_raddr, sp_waddr, dn_raddr, dn_waddr;
	logic [ENT_W-1:0]  sp_wdata;
	logic [DN_W-1:0]   dn_wdata;

	logic              fill_inc, fill_dec, accept, load_out, ent_ok, present;
	logic [FILL_W-1:0] cur_fill;
	logic [FILL_W-1:0] last_idx;
	logic [CNT_W-1:0]  t_next;

	alloc_ctl_t  actl;
	alloc_stat_t astat;
	logic [ENT_W-1:0] pop_id;

	sses_alloc u_alloc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (actl),
		.stat   (astat),
		.pop_id (pop_id)
	);

	assign active   = (types_q > CNT_W'(TYPE_SLOTS)) ? CNT_W'(TYPE_SLOTS) : types_q;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == ST_EMIT) && !(out_valid_q && out_stall);
	assign ent_ok   = (entity_id != '0) && ({1'b0, entity_id} < astat.next_id);
	assign cur_fill = fill_q[t_q];
	assign last_idx = cur_fill - 1'b1;
	assign t_next   = {1'b0, t_q} + 1'b1;
	// An entry is a member only if its index is live and the dense slot points back.
	assign present  = ({1'b0, hole_q} < cur_fill) && (dn_rdata_q[DN_W-1 -: ENT_W] == e_q);

	always_comb begin
		state_d    = state_q;
		t_d        = t_q;
		hole_d     = hole_q;
		res_new_d  = res_new_q;
		res_data_d = res_data_q;
		res_stat_d = res_stat_q;
		sp_re      = 1'b0;
		sp_raddr   = {t_q, e_q};
		sp_we      = 1'b0;
		sp_waddr   = {t_q, e_q};
		sp_wdata   = hole_q;
		dn_re      = 1'b0;
		dn_raddr   = {t_q, hole_q};
		dn_we      = 1'b0;
		dn_waddr   = {t_q, hole_q};
		dn_wdata   = dn_rdata_q;
		fill_inc   = 1'b0;
		fill_dec   = 1'b0;
		actl       = '0;
		actl.push_id = e_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_new_d  = '0;
					res_data_d = '0;
					res_stat_d = STAT_OK;
					state_d    = ST_EMIT;
					t_d        = comp_type;
					priority case (op)
						OP_CREATE: begin
							if (!astat.empty) begin
								actl.pop = 1'b1;
								state_d  = ST_POP;
							end else if (astat.fresh_out) begin
								res_stat_d = STAT_FULL;
							end else begin
								res_new_d       = astat.next_id[ENT_W-1:0];
								actl.take_fresh = 1'b1;
							end
						end
						OP_DESTROY: begin
							t_d = '0;
							if (!ent_ok) begin
								res_stat_d = STAT_BAD_ENTITY;
							end else if (astat.full) begin
								res_stat_d = STAT_FULL;
							end else if (active == '0) begin
								actl.push    = 1'b1;
								actl.push_id = entity_id;
							end else begin
								sp_re    = 1'b1;
								sp_raddr = {TYPE_W'(0), entity_id};
								state_d  = ST_LOOKUP;
							end
						end
						OP_ADD, OP_REMOVE, OP_GET: begin
							if ({1'b0, comp_type} >= active) begin
								res_stat_d = STAT_BAD_TYPE;
							end else if (!ent_ok) begin
								res_stat_d = STAT_BAD_ENTITY;
							end else begin
								sp_re    = 1'b1;
								sp_raddr = {comp_type, entity_id};
								state_d  = ST_LOOKUP;
							end
						end
						default: res_stat_d = STAT_BAD_ENTITY;
					endcase
				end
			end
			ST_LOOKUP: begin
				hole_d   = sp_rdata_q;
				dn_re    = 1'b1;
				dn_raddr = {t_q, sp_rdata_q};
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = ST_EMIT;
				priority case (op_q)
					OP_ADD: begin
						if (present) begin
							res_stat_d = STAT_PRESENT;
						end else if (cur_fill == FILL_W'(ENTITY_SLOTS)) begin
							res_stat_d = STAT_FULL;
						end else begin
							dn_we    = 1'b1;
							dn_waddr = {t_q, cur_fill[ENT_W-1:0]};
							dn_wdata = {e_q, d_q};
							sp_we    = 1'b1;
							sp_wdata = cur_fill[ENT_W-1:0];
							fill_inc = 1'b1;
						end
					end
					OP_GET: begin
						if (present) begin
							res_data_d = dn_rdata_q[DATA_W-1:0];
						end else begin
							res_stat_d = STAT_ABSENT;
						end
					end
					default: begin
						if (present) begin
							dn_re    = 1'b1;
							dn_raddr = {t_q, last_idx[ENT_W-1:0]};
							state_d  = ST_MOVE;
						end else if (op_q == OP_REMOVE) begin
							res_stat_d = STAT_ABSENT;
						end else if (t_next < active) begin
							t_d      = t_next[TYPE_W-1:0];
							sp_re    = 1'b1;
							sp_raddr = {t_next[TYPE_W-1:0], e_q};
							state_d  = ST_LOOKUP;
						end else begin
							actl.push = 1'b1;
						end
					end
				endcase
			end
			ST_MOVE: begin
				// The last dense entry fills the hole and its sparse slot follows it.
				dn_we    = 1'b1;
				sp_we    = 1'b1;
				sp_waddr = {t_q, dn_rdata_q[DN_W-1 -: ENT_W]};
				fill_dec = 1'b1;
				state_d  = ST_EMIT;
				if (op_q == OP_DESTROY) begin
					if (t_next < active) begin
						t_d      = t_next[TYPE_W-1:0];
						sp_re    = 1'b1;
						sp_raddr = {t_next[TYPE_W-1:0], e_q};
						state_d  = ST_LOOKUP;
					end else begin
						actl.push = 1'b1;
					end
				end
			end
			ST_POP: begin
				res_new_d = pop_id;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			types_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TYPE_SLOTS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				types_q <= cfg_wr_data;
			end
			if (fill_inc) begin
				fill_q[t_q] <= cur_fill + 1'b1;
			end else if (fill_dec) begin
				fill_q[t_q] <= last_idx;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			e_q  <= entity_id;
			d_q  <= data_in;
		end
		t_q        <= t_d;
		hole_q     <= hole_d;
		res_new_q  <= res_new_d;
		res_data_q <= res_data_d;
		res_stat_q <= res_stat_d;
		if (load_out) begin
			out_new_q  <= res_new_q;
			out_data_q <= res_data_q;
			out_stat_q <= res_stat_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sp_we) begin
			sp_mem[sp_waddr] <= sp_wdata;
		end
		if (sp_re) begin
			sp_rdata_q <= sp_mem[sp_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (dn_we) begin
			dn_mem[dn_waddr] <= dn_wdata;
		end
		if (dn_re) begin
			dn_rdata_q <= dn_mem[dn_raddr];
		end
	end

	assign out_valid  = out_valid_q;
	assign new_entity = out_new_q;
	assign data_out   = out_data_q;
	assign status     = out_stat_q;

	`SSES_ASSERT_NEXT(a_emit_loads, load_out, out_valid_q, "result lost on its way out")
	`SSES_ASSERT(a_new_ok, !out_valid_q || out_new_q == '0 || out_stat_q == STAT_OK, "id with failure")
	`SSES_ASSERT(a_data_ok, !out_valid_q || out_data_q == '0 || out_stat_q == STAT_OK, "data with failure")
	`SSES_ASSERT(a_alloc_excl, !(actl.push && actl.pop), "free stack pushed and popped together")
endmodule
`default_nettype wire

@@ tb/sv/sparse_set_entity_store_checker.sv @@
// Result checker for the entity store: predicts each result and compares it.
module sparse_set_entity_store_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [2:0]  op,
	input  wire  [7:0]  entity_id,
	input  wire  [2:0]  comp_type,
	input  wire  [31:0] data_in,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [7:0]  new_entity,
	input  wire  [31:0] data_out,
	input  wire  [2:0]  status,
	input  wire         cfg_wr_en,
	input  wire  [3:0]  cfg_wr_data,
	output int          pending,
	output int          failures
);
	import sses_pkg::*;

	typedef struct packed {
		logic [7:0]  ent;
		logic [31:0] word;
		logic [2:0]  stat;
	} outcome_t;

	outcome_t outcome_q[$];

	logic [3:0]        type_count;
	logic [8:0]        fresh_id;
	logic [8:0]        stack_depth;
	logic [7:0]        id_stack[ENTITY_SLOTS];
	logic              member[TYPE_SLOTS][ENTITY_SLOTS];
	logic [7:0]        slot_of[TYPE_SLOTS][ENTITY_SLOTS];
	logic [7:0]        owner[TYPE_SLOTS][ENTITY_SLOTS];
	logic [31:0]       word_of[TYPE_SLOTS][ENTITY_SLOTS];
	logic [8:0]        fill[TYPE_SLOTS];

	assign pending = outcome_q.size();

	function automatic int active_types();
		return (type_count < TYPE_SLOTS) ? int'(type_count) : TYPE_SLOTS;
	endfunction

	function automatic bit entity_live(logic [7:0] e);
		return e != 8'd0 && {1'b0, e} < fresh_id;
	endfunction

	// Swap-remove: the last dense entry moves into the hole.
	task automatic swap_out(int t, logic [7:0] e);
		logic [7:0] hole;
		logic [7:0] last;
		logic [7:0] mover;
		hole = slot_of[t][e];
		last = 8'(fill[t] - 1'b1);
		mover = owner[t][last];
		owner[t][hole] = mover;
		word_of[t][hole] = word_of[t][last];
		slot_of[t][mover] = hole;
		member[t][e] = 1'b0;
		fill[t] = fill[t] - 1'b1;
	endtask

	task automatic predict_item(logic [2:0] o, logic [7:0] e, logic [2:0] t, logic [31:0] d);
		outcome_t r;
		r = '0;
		r.stat = STAT_OK;
		if (o == OP_CREATE) begin
			if (stack_depth > 0) begin
				stack_depth = stack_depth - 1'b1;
				r.ent = id_stack[stack_depth[7:0]];
			end else if (fresh_id >= ENTITY_SLOTS) begin
				r.stat = STAT_FULL;
			end else begin
				r.ent = fresh_id[7:0];
				fresh_id = fresh_id + 1'b1;
			end
		end else if (o == OP_DESTROY) begin
			if (!entity_live(e)) begin
				r.stat = STAT_BAD_ENTITY;
			end else if (stack_depth >= ENTITY_SLOTS) begin
				r.stat = STAT_FULL;
			end else begin
				for (int k = 0; k < active_types(); k++)
					if (member[k][e])
						swap_out(k, e);
				id_stack[stack_depth[7:0]] = e;
				stack_depth = stack_depth + 1'b1;
			end
		end else if (o == OP_ADD || o == OP_REMOVE || o == OP_GET) begin
			if (int'(t) >= active_types()) begin
				r.stat = STAT_BAD_TYPE;
			end else if (!entity_live(e)) begin
				r.stat = STAT_BAD_ENTITY;
			end else if (o == OP_ADD) begin
				if (member[t][e]) begin
					r.stat = STAT_PRESENT;
				end else if (fill[t] >= ENTITY_SLOTS) begin
					r.stat = STAT_FULL;
				end else begin
					owner[t][fill[t][7:0]] = e;
					word_of[t][fill[t][7:0]] = d;
					slot_of[t][e] = fill[t][7:0];
					member[t][e] = 1'b1;
					fill[t] = fill[t] + 1'b1;
				end
			end else if (!member[t][e]) begin
				r.stat = STAT_ABSENT;
			end else if (o == OP_REMOVE) begin
				swap_out(t, e);
			end else begin
				r.word = word_of[t][slot_of[t][e]];
			end
		end else begin
			r.stat = STAT_BAD_ENTITY;
		end
		outcome_q.push_back(r);
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t w;
		if (!arst_n) begin
			type_count = '0;
			fresh_id = 9'd1;
			stack_depth = '0;
			failures = 0;
			for (int t = 0; t < TYPE_SLOTS; t++) begin
				fill[t] = '0;
				for (int e = 0; e < ENTITY_SLOTS; e++)
					member[t][e] = 1'b0;
			end
			outcome_q.delete();
		end else begin
			if (cfg_wr_en)
				type_count = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_item(op, entity_id, comp_type, data_in);
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					report("unexpected result status", 32'(status), 32'd0);
				end else begin
					w = outcome_q.pop_front();
					if (new_entity !== w.ent)
						report("new_entity", 32'(new_entity), 32'(w.ent));
					if (data_out !== w.word)
						report("data_out", data_out, w.word);
					if (status !== w.stat)
						report("status", 32'(status), 32'(w.stat));
				end
			end
		end
	end
endmodule

@@ tb/sv/sparse_set_entity_store_test.sv @@
// Testbench top for the entity store: clock, reset, stimulus and verdict.
module sparse_set_entity_store_test;
	import sses_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [7:0]  entity_id;
	logic [2:0]  comp_type;
	logic [31:0] data_in;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  new_entity;
	logic [31:0] data_out;
	logic [2:0]  status;
	logic        cfg_wr_en;
	logic [3:0]  cfg_wr_data;
	int          pending;
	int          failures;

	sparse_set_entity_store u_top (.*);

	sparse_set_entity_store_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stalls, with one long hold-off early on so the block backs up.
	initial begin
		int r;
		out_stall = 1'b0;
		@(posedge arst_n);
		for (int k = 0; ; k++) begin
			r = $urandom_range(0, 99);
			if (k == 40) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else if (r >= 60) begin
				out_stall <= 1'b1;
				repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	task automatic send(logic [2:0] o, logic [7:0] e, logic [2:0] t, logic [31:0] d);
		int r;
		in_valid <= 1'b1;
		op <= o;
		entity_id <= e;
		comp_type <= t;
		data_in <= d;
		do @(posedge clk); while (in_stall);
		r = $urandom_range(0, 99);
		if (r >= 65) begin
			in_valid <= 1'b0;
			repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 50)) @(posedge clk);
		end
	endtask

	// Waits for every result and lets a destroy walk finish before a register write.
	task automatic set_types(logic [3:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_item(int span);
		int r;
		logic [2:0] o;
		logic [7:0] e;
		r = $urandom_range(0, 99);
		if (r < 12) o = OP_CREATE;
		else if (r < 20) o = OP_DESTROY;
		else if (r < 50) o = OP_ADD;
		else if (r < 65) o = OP_REMOVE;
		else if (r < 95) o = OP_GET;
		else o = 3'($urandom_range(5, 7));
		e = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, span));
		send(o, e, 3'($urandom), $urandom);
	endtask

	initial begin
		logic [3:0] cfg_steps[5];
		cfg_steps = '{4'd3, 4'd8, 4'd1, 4'd15, 4'd5};
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_CREATE;
		entity_id = '0;
		comp_type = '0;
		data_in = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No types registered yet: every component access is a bad type.
		send(OP_CREATE, 8'd0, 3'd0, 32'd0);
		send(OP_ADD, 8'd1, 3'd0, 32'h1234_5678);
		send(OP_GET, 8'd1, 3'd7, 32'd0);
		set_types(4'd15);
		send(OP_CREATE, 8'd0, 3'd0, 32'd0);
		send(OP_ADD, 8'd1, 3'd0, 32'hFFFF_FFFF);
		send(OP_ADD, 8'd1, 3'd0, 32'h0);
		send(OP_ADD, 8'd2, 3'd0, 32'h0);
		send(OP_GET, 8'd1, 3'd0, 32'd0);
		send(OP_REMOVE, 8'd1, 3'd0, 32'd0);
		send(OP_GET, 8'd1, 3'd0, 32'd0);
		send(OP_GET, 8'd2, 3'd0, 32'd0);
		send(OP_ADD, 8'd1, 3'd7, 32'hA5A5_5A5A);
		send(OP_ADD, 8'd2, 3'd7, 32'h5A5A_A5A5);
		send(OP_DESTROY, 8'd1, 3'd0, 32'd0);
		send(OP_GET, 8'd2, 3'd7, 32'd0);
		send(OP_DESTROY, 8'd1, 3'd0, 32'd0);
		send(OP_CREATE, 8'd0, 3'd0, 32'd0);
		send(OP_CREATE, 8'd0, 3'd0, 32'd0);
		send(OP_GET, 8'd255, 3'd7, 32'd0);
		send(OP_DESTROY, 8'd0, 3'd0, 32'd0);
		send(OP_DESTROY, 8'd200, 3'd0, 32'd0);
		send(3'd5, 8'd1, 3'd1, 32'd0);
		send(3'd6, 8'd1, 3'd1, 32'd0);
		send(3'd7, 8'd1, 3'd1, 32'd0);

		for (int p = 0; p < 5; p++) begin
			set_types(cfg_steps[p]);
			repeat (55) random_item(p < 3 ? 12 : 40);
		end

		// Run the ids out, then overflow the free stack with repeated destroys.
		set_types(4'd1);
		repeat (300) send(OP_CREATE, 8'd0, 3'd0, 32'd0);
		send(OP_ADD, 8'd255, 3'd0, 32'hDEAD_BEEF);
		send(OP_GET, 8'd255, 3'd0, 32'd0);
		set_types(4'd0);
		repeat (260) send(OP_DESTROY, 8'd3, 3'd0, 32'd0);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
